@@ hdl/lr4hp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr4hp_pkg: shared types and constants of the fourth-order highpass
// Sample, coefficient and product types, channel payload structs, the
// register index codes and the fixed-point constants of the datapath.
// ----------------------------------------------------------------------------
package lr4hp_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int CHAN_BITS    = 4;
  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 32;
  localparam int COEF_FRAC    = 28;
  localparam int NUM_COEFS    = 5;
  localparam int HIST_TAPS    = 4;
  // Numerator taps 1,-4,6,-4,1 grow the sample range by 16, hence four bits.
  localparam int NUM_BITS     = SAMPLE_BITS + 4;
  localparam int PROD_BITS    = COEF_BITS + NUM_BITS;
  localparam int ACC_BITS     = PROD_BITS + 4;
  localparam int CFG_IDX_BITS = 3;

  localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(2 ** (COEF_FRAC - 1));
  localparam logic signed [ACC_BITS-1:0] SAT_MAX    = ACC_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_MIN    = -SAT_MAX - ACC_BITS'(1);

  typedef logic [SAMPLE_BITS-1:0]      smp_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GAIN = 3'd0,
    REG_FB1  = 3'd1,
    REG_FB2  = 3'd2,
    REG_FB3  = 3'd3,
    REG_FB4  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAN_BITS-1:0]          channel_number;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0]          channel_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;
  } out_t;

  // One history row per channel; element 0 is the most recent sample.
  typedef struct packed {
    smp_t [HIST_TAPS-1:0] x_hist;
    smp_t [HIST_TAPS-1:0] y_hist;
  } row_t;

endpackage

@@ hdl/lr4hp_hist_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr4hp_hist_mem: per-channel history memory
// One row per channel holding the last four inputs and outputs. A row that
// was never written since reset reads as zero through its valid bit.
// ----------------------------------------------------------------------------
module lr4hp_hist_mem #(
  parameter int CHANNELS = lr4hp_pkg::CHANNELS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       rd_en,
  input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] rd_idx,
  input  logic                                       wr_en,
  input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] wr_idx,
  input  lr4hp_pkg::row_t                            wr_row,
  output lr4hp_pkg::row_t                            rd_row
);
  import lr4hp_pkg::*;

  row_t                hist_ram [CHANNELS];
  logic [CHANNELS-1:0] row_vld_r;
  logic [CHANNELS-1:0] row_vld_nxt;
  row_t                rd_row_r;
  logic                rd_vld_r;

  always_comb begin
    row_vld_nxt = row_vld_r;
    if (wr_en) begin
      row_vld_nxt[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else begin
      row_vld_r <= row_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_ram[wr_idx] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= hist_ram[rd_idx];
      rd_vld_r <= row_vld_r[rd_idx];
    end
  end

  assign rd_row = rd_vld_r ? rd_row_r : '0;

endmodule

@@ hdl/lr4hp_products.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr4hp_products: numerator and coefficient products
// Forms the binomial numerator from the new sample and its input history
// and multiplies it and the four past outputs by their coefficients.
// ----------------------------------------------------------------------------
module lr4hp_products (
  input  logic signed [lr4hp_pkg::SAMPLE_BITS-1:0] sample,
  input  lr4hp_pkg::row_t                          row,
  input  lr4hp_pkg::coef_t                         coef [lr4hp_pkg::NUM_COEFS],
  output lr4hp_pkg::prod_t                         prod [lr4hp_pkg::NUM_COEFS]
);
  import lr4hp_pkg::*;

  logic signed [NUM_BITS-1:0] xe0, xe1, xe2, xe3, xe4;
  logic signed [NUM_BITS-1:0] num;

  assign xe0 = NUM_BITS'(sample);
  assign xe1 = NUM_BITS'($signed(row.x_hist[0]));
  assign xe2 = NUM_BITS'($signed(row.x_hist[1]));
  assign xe3 = NUM_BITS'($signed(row.x_hist[2]));
  assign xe4 = NUM_BITS'($signed(row.x_hist[3]));

  // Taps 1,-4,6,-4,1 as shifts; the total always fits NUM_BITS.
  assign num = xe0 - (xe1 <<< 2) + (xe2 <<< 2) + (xe2 <<< 1) - (xe3 <<< 2) + xe4;

  always_comb begin
    prod[0] = PROD_BITS'(coef[0]) * PROD_BITS'(num);
    for (int i = 0; i < HIST_TAPS; i++) begin
      prod[i+1] = PROD_BITS'(coef[i+1]) * PROD_BITS'($signed(row.y_hist[i]));
    end
  end

endmodule

@@ hdl/lr4hp_round_sat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr4hp_round_sat: accumulate, round and saturate
// Sums the feedforward product minus the feedback products, rounds half up
// at the coefficient binary point and clamps to the sample range.
// ----------------------------------------------------------------------------
module lr4hp_round_sat (
  input  lr4hp_pkg::prod_t                         prod [lr4hp_pkg::NUM_COEFS],
  output logic signed [lr4hp_pkg::SAMPLE_BITS-1:0] sample
);
  import lr4hp_pkg::*;

  logic signed [ACC_BITS-1:0] acc;
  logic signed [ACC_BITS-1:0] shf;

  always_comb begin
    acc = ACC_BITS'(prod[0]) + ROUND_HALF;
    for (int i = 1; i < NUM_COEFS; i++) begin
      acc = acc - ACC_BITS'(prod[i]);
    end
    shf = acc >>> COEF_FRAC;
    if (shf > SAT_MAX) begin
      sample = SAMPLE_BITS'(SAT_MAX);
    end else if (shf < SAT_MIN) begin
      sample = SAMPLE_BITS'(SAT_MIN);
    end else begin
      sample = SAMPLE_BITS'(shf);
    end
  end

endmodule

@@ hdl/linkwitz_riley4_highpass_iir.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linkwitz_riley4_highpass_iir: multichannel fourth-order highpass, DF-I
// Fixed-point IIR with gain*(1,-4,6,-4,1) numerator and four feedback
// coefficients in Q4.28, per-channel history, rounded and saturated output.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the in_ channel as (channel_number, sample_in) and each
// transfer produces exactly one out_ transfer with the filtered sample of
// that channel, in arrival order. Coefficients are written through the cfg_
// channel (index 0 gain, 1 to 4 the feedback terms); the port is always
// ready and writes to other indexes are dropped. Write them only while no
// sample is in flight.
// A sample taken passes through stage 1, stage 2 and the output register
// before it shows on out_valid. Samples of different channels are taken
// one per cycle while the output is not stalled. A sample whose channel
// still has an item in the two compute stages waits until that item has
// written its history back, so a stream of one channel takes no new sample
// before the last one is through the history memory read-modify-write loop.
// Reset zeroes the coefficients and marks every history row invalid, which
// reads as all-zero history. When the receiver stalls, the result stays in
// the output register and the stages behind it keep filling until full.
// Channels at or above CHANNELS return a zero sample and leave no history.
// ----------------------------------------------------------------------------
module linkwitz_riley4_highpass_iir #(
  parameter int CHANNELS = lr4hp_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lr4hp_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lr4hp_pkg::out_t                     out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lr4hp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lr4hp_pkg::COEF_BITS-1:0]     cfg_data
);
  import lr4hp_pkg::*;

  localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Coefficient registers.
  coef_t coef_r   [NUM_COEFS];
  coef_t coef_nxt [NUM_COEFS];

  // Stage 1: accepted item, history read lands alongside it.
  logic                 s1_vld_r, s1_vld_nxt;
  in_t                  s1_item_r;
  logic                 s1_inr_r;

  // Stage 2: registered products plus what the history write-back needs.
  logic                 s2_vld_r, s2_vld_nxt;
  logic [CHAN_BITS-1:0] s2_ch_r;
  logic                 s2_inr_r;
  smp_t                 s2_x_r;
  row_t                 s2_row_r;
  prod_t                s2_prod_r [NUM_COEFS];

  // Output register.
  logic                 out_vld_r, out_vld_nxt;
  out_t                 out_item_r;

  logic                 in_fire;
  logic                 in_inr;
  logic                 hazard;
  logic                 out_free;
  logic                 s2_en;
  logic                 s1_en;
  logic                 rd_en;
  logic                 wr_en;
  row_t                 rd_row;
  row_t                 wr_row;
  prod_t                prod [NUM_COEFS];
  logic signed [SAMPLE_BITS-1:0] sat_y;

  // -------------------------------------------------------------------------
  // Configuration: always ready, unknown indexes ignored.
  // -------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid) begin
      case (cfg_idx_e'(cfg_index))
        REG_GAIN: coef_nxt[0] = cfg_data;
        REG_FB1:  coef_nxt[1] = cfg_data;
        REG_FB2:  coef_nxt[2] = cfg_data;
        REG_FB3:  coef_nxt[3] = cfg_data;
        REG_FB4:  coef_nxt[4] = cfg_data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_r[i] <= '0;
      end
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Flow control. Each stage moves when the one after it is empty or moving.
  // A sample whose channel sits in stage 1 or 2 would read stale history, so
  // it is held off until that item has been written back.
  // -------------------------------------------------------------------------
  assign out_free = !out_vld_r || out_ready;
  assign s2_en    = !s2_vld_r || out_free;
  assign s1_en    = !s1_vld_r || s2_en;
  assign hazard   = (s1_vld_r && (s1_item_r.channel_number == in_data.channel_number)) ||
                    (s2_vld_r && (s2_ch_r == in_data.channel_number));
  assign in_ready = s1_en && !hazard;
  assign in_fire  = in_valid && in_ready;
  assign in_inr   = 32'(in_data.channel_number) < 32'(CHANNELS);

  assign rd_en = in_fire && in_inr;
  assign wr_en = s2_vld_r && out_free && s2_inr_r;

  always_comb begin
    s1_vld_nxt  = s1_en ? in_fire : s1_vld_r;
    s2_vld_nxt  = s2_en ? s1_vld_r : s2_vld_r;
    out_vld_nxt = out_free ? s2_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // History memory, read when a sample is taken, written when its result
  // leaves stage 2.
  // -------------------------------------------------------------------------
  lr4hp_hist_mem #(
    .CHANNELS (CHANNELS)
  ) u_hist_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (rd_en),
    .rd_idx (IDX_BITS'(in_data.channel_number)),
    .wr_en  (wr_en),
    .wr_idx (IDX_BITS'(s2_ch_r)),
    .wr_row (wr_row),
    .rd_row (rd_row)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
      s1_inr_r  <= in_inr;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1 to 2: numerator and the five multiplications.
  // -------------------------------------------------------------------------
  lr4hp_products u_products (
    .sample (s1_item_r.sample_in),
    .row    (rd_row),
    .coef   (coef_r),
    .prod   (prod)
  );

  always_ff @(posedge clk) begin
    if (s1_vld_r && s2_en) begin
      s2_ch_r   <= s1_item_r.channel_number;
      s2_inr_r  <= s1_inr_r;
      s2_x_r    <= s1_item_r.sample_in;
      s2_row_r  <= rd_row;
      s2_prod_r <= prod;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2 to output: sum, round, saturate; the saturated value is what
  // enters the output history.
  // -------------------------------------------------------------------------
  lr4hp_round_sat u_round_sat (
    .prod   (s2_prod_r),
    .sample (sat_y)
  );

  always_comb begin
    wr_row.x_hist[0] = s2_x_r;
    wr_row.y_hist[0] = sat_y;
    for (int i = 1; i < HIST_TAPS; i++) begin
      wr_row.x_hist[i] = s2_row_r.x_hist[i-1];
      wr_row.y_hist[i] = s2_row_r.y_hist[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r && out_free) begin
      out_item_r.channel_out <= s2_ch_r;
      out_item_r.sample_out  <= s2_inr_r ? sat_y : '0;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // -------------------------------------------------------------------------
  // Checks.
  // -------------------------------------------------------------------------
  // The two compute stages never hold the same channel at once.
  a_no_chan_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s2_vld_r) |-> (s1_item_r.channel_number != s2_ch_r))
    else $error("two in-flight items share a channel");

  // A history write-back always comes with a result entering the output.
  a_wb_has_result : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_vld_r)
    else $error("history written without a result");

  // A sample is never taken while its channel is still being computed.
  a_fire_no_hazard : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !(s2_vld_r && s1_vld_r && (s2_ch_r == s1_item_r.channel_number)))
    else $error("sample taken over an in-flight item of its channel");

endmodule
